[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication or plain condition, disabled in reset
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// condition in one cycle implies a condition in the next one
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[rtl/core/stng_pkg.sv]
// ----------------------------------------------------------------------------
// stng_pkg
// shared types and constants of the stereo tone and noise generator
// ----------------------------------------------------------------------------
package stng_pkg;

  typedef struct packed {
    logic        buffer_start;
    logic        noise_on;
    logic [16:0] pan;
    logic [30:0] target_increment;
  } item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } result_t;

  localparam logic [16:0] UNITY_Q16    = 17'h10000;
  localparam logic [16:0] VOLUME_RESET = 17'd6554;
  localparam logic [16:0] KEEP_Q16     = 17'd62259;
  localparam logic [16:0] MOVE_Q16     = 17'd3277;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // odd sine polynomial coefficients, Q30
  localparam logic [63:0] C1_Q30 = 64'd1686629713;
  localparam logic [63:0] C3_Q30 = 64'd693598668;
  localparam logic [63:0] C5_Q30 = 64'd85569306;
  localparam logic [63:0] C7_Q30 = 64'd5026995;
  localparam logic [63:0] C9_Q30 = 64'd172272;

  // one galois shift, right shifting
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
  endfunction

endpackage

[rtl/core/stng_mul.sv]
// ----------------------------------------------------------------------------
// stng_mul
// shared unsigned multiplier with registered product and load enable
// ----------------------------------------------------------------------------
module stng_mul #(
  parameter int A_W = 32,
  parameter int B_W = 17
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
    end
  end

endmodule

[rtl/core/stng_sine_rom.sv]
// ----------------------------------------------------------------------------
// stng_sine_rom
// quarter-wave sine magnitude table with registered read
// ----------------------------------------------------------------------------
module stng_sine_rom import stng_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16,
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1),
  localparam int MAG_W  = SAMPLE_BITS - 1
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [MAG_W-1:0]  data
);

  typedef logic [MAG_W-1:0] rom_t [SINE_TABLE_DEPTH+1];

  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    x2 = (x * x) >> 30;
    p  = C7_Q30 - ((x2 * C9_Q30) >> 30);
    p  = C5_Q30 - ((x2 * p) >> 30);
    p  = C3_Q30 - ((x2 * p) >> 30);
    p  = C1_Q30 - ((x2 * p) >> 30);
    return (x * p) >> 30;
  endfunction

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] peak;
    peak = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (64'(k) << 30) / SINE_TABLE_DEPTH;
      s = quarter_sine_q30(x);
      v = (s * peak + (64'd1 << 29)) >> 30;
      if (v > peak) begin
        v = peak;
      end
      r[k] = v[MAG_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule

[rtl/core/stereo_tone_noise_generator.sv]
// ----------------------------------------------------------------------------
// stereo_tone_noise_generator
// sine nco or lfsr noise source with volume and stereo pan
// ----------------------------------------------------------------------------
// One input beat gives one stereo output beat. A single shared multiplier,
// 32 by 17 bits at the default phase width, does every product in turn under
// a small sequencer. Tone mode computes the phase, table index, address, sine
// magnitude and the gains; buffer_start adds increment smoothing (two extra
// products and a sum), and noise mode skips the table. Input is stalled from
// accept until the result is loaded into the output register, so the next item
// is taken while it waits to be drained. The sine table is a quarter-wave rom
// with a registered read, addressed once per tone item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_tone_noise_generator import stng_pkg::*; #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [16:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        sample_valid,
  input  logic        sample_stall,
  output result_t     sample
);

  localparam int A_W    = (PHASE_BITS - 2 > 32) ? PHASE_BITS - 2 : 32;
  localparam int B_W    = 17;
  localparam int P_W    = A_W + B_W;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MAG_W  = SAMPLE_BITS - 1;
  localparam int STEP_W = PHASE_BITS + 32;
  localparam int INC_UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int INC_DN = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
  localparam int Q15_W  = MAG_W + 16;
  localparam int MAG_UP = (SAMPLE_BITS >= 16) ? 0 : 16 - SAMPLE_BITS;
  localparam int MAG_DN = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_KEEP   = 4'd1;
  localparam logic [3:0] S_MOVE   = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_PHASE  = 4'd4;
  localparam logic [3:0] S_INDEX  = 4'd5;
  localparam logic [3:0] S_ADDR   = 4'd6;
  localparam logic [3:0] S_FETCH  = 4'd7;
  localparam logic [3:0] S_MAG    = 4'd8;
  localparam logic [3:0] S_NOISE  = 4'd9;
  localparam logic [3:0] S_VOL_L  = 4'd10;
  localparam logic [3:0] S_GAIN_L = 4'd11;
  localparam logic [3:0] S_VOL_R  = 4'd12;
  localparam logic [3:0] S_GAIN_R = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]            state;
  logic [3:0]            state_next;
  logic [16:0]           volume;
  logic [PHASE_BITS-1:0] phase;
  logic [31:0]           inc;
  logic [15:0]           lfsr;
  logic [30:0]           target;
  logic [16:0]           pan;
  logic                  neg;
  logic [14:0]           lmag;
  logic [14:0]           rmag;
  logic [14:0]           lres;
  logic [P_W-1:0]        partial;
  logic [IDX_W-1:0]      rom_addr;
  logic [MAG_W-1:0]      rom_q;

  logic                  item_take;
  logic                  out_free;
  logic [16:0]           vol_c;
  logic [16:0]           pan_c;
  logic                  mul_en;
  logic [A_W-1:0]        mul_a;
  logic [B_W-1:0]        mul_b;
  logic [P_W-1:0]        prod;
  logic [STEP_W-1:0]     step_ext;
  logic [P_W:0]          smooth_sum;
  logic [IDX_W-1:0]      idx;
  logic [Q15_W-1:0]      q15_ext;
  logic [15:0]           lfsr_a;
  logic [15:0]           lfsr_b;
  logic [15:0]           left_ext;
  logic [15:0]           right_ext;

  assign item_stall = rst || (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !sample_valid || !sample_stall;

  assign vol_c = (volume > UNITY_Q16) ? UNITY_Q16 : volume;
  assign pan_c = (item.pan > UNITY_Q16) ? UNITY_Q16 : item.pan;

  // increment is over 2^32 turns, phase over 2^PHASE_BITS
  assign step_ext   = (STEP_W'(inc) << INC_UP) >> INC_DN;
  assign smooth_sum = {1'b0, partial} + {1'b0, prod};
  assign idx        = prod[PHASE_BITS-2 +: IDX_W];
  assign q15_ext    = (Q15_W'(rom_q) << MAG_UP) >> MAG_DN;
  assign lfsr_a     = lfsr_next(lfsr);
  assign lfsr_b     = lfsr_next(lfsr_a);
  assign left_ext   = {1'b0, lres};
  assign right_ext  = {1'b0, prod[30:16]};

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_KEEP: begin
        mul_a = A_W'(inc);
        mul_b = KEEP_Q16;
      end
      S_MOVE: begin
        mul_a = A_W'(target);
        mul_b = MOVE_Q16;
      end
      S_INDEX: begin
        mul_a = A_W'(phase[PHASE_BITS-3:0]);
        mul_b = B_W'(SINE_TABLE_DEPTH);
      end
      S_VOL_L: begin
        mul_a = A_W'(lmag);
        mul_b = vol_c;
      end
      S_GAIN_L: begin
        mul_a = A_W'(prod[30:16]);
        mul_b = UNITY_Q16 - pan;
      end
      S_VOL_R: begin
        mul_a = A_W'(rmag);
        mul_b = vol_c;
      end
      S_GAIN_R: begin
        mul_a = A_W'(prod[30:16]);
        mul_b = pan;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  stng_mul #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  stng_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_take) begin
          if (item.noise_on) begin
            state_next = S_NOISE;
          end else if (item.buffer_start) begin
            state_next = S_KEEP;
          end else begin
            state_next = S_PHASE;
          end
        end
      end
      S_KEEP:   state_next = S_MOVE;
      S_MOVE:   state_next = S_SUM;
      S_SUM:    state_next = S_PHASE;
      S_PHASE:  state_next = S_INDEX;
      S_INDEX:  state_next = S_ADDR;
      S_ADDR:   state_next = S_FETCH;
      S_FETCH:  state_next = S_MAG;
      S_MAG:    state_next = S_VOL_L;
      S_NOISE:  state_next = S_VOL_L;
      S_VOL_L:  state_next = S_GAIN_L;
      S_GAIN_L: state_next = S_VOL_R;
      S_VOL_R:  state_next = S_GAIN_R;
      S_GAIN_R: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      volume       <= VOLUME_RESET;
      phase        <= '0;
      inc          <= '0;
      lfsr         <= LFSR_SEED;
      rom_addr     <= '0;
      sample_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        volume <= cfg_data;
      end
      if (state == S_DONE && out_free) begin
        sample_valid <= 1'b1;
      end else if (sample_valid && !sample_stall) begin
        sample_valid <= 1'b0;
      end
      unique case (state)
        S_SUM:   inc   <= smooth_sum[47:16];
        S_PHASE: phase <= phase + step_ext[PHASE_BITS-1:0];
        S_ADDR: begin
          // quarters one and three run the table backward
          rom_addr <= phase[PHASE_BITS-2] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
        end
        S_NOISE: lfsr <= lfsr_b;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      target <= item.target_increment;
      pan    <= pan_c;
    end
    case (state)
      S_MOVE: partial <= prod;
      S_ADDR: neg     <= phase[PHASE_BITS-1];
      S_MAG: begin
        lmag <= q15_ext[14:0];
        rmag <= q15_ext[14:0];
      end
      S_NOISE: begin
        // left takes the first draw, right the second
        lmag <= lfsr_a[15:1];
        rmag <= lfsr_b[15:1];
        neg  <= 1'b0;
      end
      S_VOL_R: lres <= prod[30:16];
      S_DONE: begin
        if (out_free) begin
          sample.left_sample  <= $signed(neg ? (16'd0 - left_ext) : left_ext);
          sample.right_sample <= $signed(neg ? (16'd0 - right_ext) : right_ext);
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_RST(a_lfsr_nonzero, clk, rst, lfsr != 16'd0)
  `ASSERT_RST(a_rom_addr_range, clk, rst, rom_addr <= IDX_W'(SINE_TABLE_DEPTH))
  `ASSERT_RST(a_gain_fits, clk, rst, (state == S_VOL_R || state == S_DONE) |-> prod[P_W-1:31] == '0)
  `ASSERT_NEXT(a_done_holds, clk, rst, state == S_DONE && !out_free, state == S_DONE)

endmodule
